[rtl/bdq_pkg.sv]
// bdq_pkg: shared types, constants and value helpers for the bounded deque
// with search; used by every module under rtl/ except bdq_ram
package bdq_pkg;

	// storage geometry
	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// stream payload geometry
	localparam int ITEM_W      = 32;
	localparam int POS_W       = 8;
	localparam int REQ_W       = 3;
	localparam int FPOS_W      = 4;
	localparam int COUNT_OUT_W = 5;
	localparam int IN_DATA_W   = ((ITEM_W + POS_W + 7) / 8) * 8;
	localparam int RES_W       = ITEM_W + FPOS_W + 3 + COUNT_OUT_W + 1;
	localparam int OUT_DATA_W  = ((RES_W + 7) / 8) * 8;

	// width for comparing a read position against the entry count
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_TAIL = 3'd0,
		REQ_PUSH_HEAD = 3'd1,
		REQ_POP_TAIL  = 3'd2,
		REQ_POP_HEAD  = 3'd3,
		REQ_READ      = 3'd4,
		REQ_FIND      = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_RANGE    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_SCAN,
		S_DONE
	} state_t;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic                   empty_flag;
		logic [COUNT_OUT_W-1:0] entry_count;
		status_t                status;
		logic [FPOS_W-1:0]      found_position;
		logic [ITEM_W-1:0]      read_value;
	} result_t;

	// sign-extend a 32-bit stream word, then keep it at storage width
	function automatic logic [VALUE_BITS-1:0] from_input(input logic [ITEM_W-1:0] raw);
		logic signed [63:0] ext;
		ext = 64'(signed'(raw));
		return ext[VALUE_BITS-1:0];
	endfunction

	// sign-extend a stored word, then cut it to the 32-bit stream width
	function automatic logic [ITEM_W-1:0] to_output(input logic [VALUE_BITS-1:0] stored);
		logic signed [63:0] ext;
		ext = 64'(signed'(stored));
		return ext[ITEM_W-1:0];
	endfunction

endpackage

[rtl/bdq_ram.sv]
// bdq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/bdq_agu.sv]
// bdq_agu: shared ring address adder and entry comparator
// depends on bdq_pkg
module bdq_agu (
	input  logic [bdq_pkg::PTR_W-1:0]      head,
	input  logic [bdq_pkg::PTR_W-1:0]      offset,
	output logic [bdq_pkg::PTR_W-1:0]      slot,
	input  logic [bdq_pkg::VALUE_BITS-1:0] entry,
	input  logic [bdq_pkg::VALUE_BITS-1:0] key,
	output logic                           hit
);
	import bdq_pkg::*;

	logic [PTR_W:0] sum;

	// head plus offset, wrapped once around the ring
	always_comb begin
		sum = {1'b0, head} + {1'b0, offset};
		if (sum >= (PTR_W+1)'(DEPTH)) begin
			sum = sum - (PTR_W+1)'(DEPTH);
		end
		slot = sum[PTR_W-1:0];
	end

	// equality compare used by the search
	assign hit = (entry == key);

endmodule

[rtl/bounded_deque_with_search_unit.sv]
// bounded_deque_with_search_unit: top level, request sequencer and output register
// depends on bdq_pkg, bdq_agu, bdq_ram
//
//  channel | direction | tdata (low bit up)                                   | tuser
//  s_*     | in        | item_value[31:0], position[39:32]                    | req_type[2:0]
//  m_*     | out       | read_value[31:0], found_position[35:32],             | -
//          |           | status[38:36], entry_count[43:39], empty_flag[44]    |
//
// one request at a time: push, pop and unknown codes go through S_EXEC and S_DONE, an
// in-range read adds S_RDWAIT (one registered RAM read), a non-empty find adds S_SCAN
// and compares one entry per step on the single ring adder and comparator.
// reset empties the deque (head and count to zero); the store itself is not cleared.
// a result waiting on m_tready does not block the next transfer on s_*; that
// request runs and holds in its last step until the output register frees.
module bounded_deque_with_search_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bdq_pkg::IN_DATA_W-1:0]  s_tdata,  // item_value, position
	input  logic [bdq_pkg::REQ_W-1:0]      s_tuser,  // req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bdq_pkg::OUT_DATA_W-1:0] m_tdata   // read_value, found_position,
	                                                 // status, entry_count, empty_flag
);
	import bdq_pkg::*;

	state_t                 state_q, state_d;
	req_t                   req_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic [POS_W-1:0]       pos_q;
	logic [PTR_W-1:0]       head_q, head_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [PTR_W-1:0]       idx_q, idx_d;
	logic [ITEM_W-1:0]      rd_q, rd_d;
	logic [PTR_W-1:0]       fpos_q, fpos_d;
	status_t                status_q, status_d;
	result_t                out_q;
	logic                   m_tvalid_q;

	logic [PTR_W-1:0]       agu_off;
	logic [PTR_W-1:0]       agu_slot;
	logic                   agu_hit;
	logic                   ram_we;
	logic [VALUE_BITS-1:0]  ram_rdata;
	logic                   in_fire;
	logic                   out_load;
	logic                   is_full;
	logic                   cnt_zero;

	// shared address and compare unit
	bdq_agu u_agu (
		.head   (head_q),
		.offset (agu_off),
		.slot   (agu_slot),
		.entry  (ram_rdata),
		.key    (val_q),
		.hit    (agu_hit)
	);

	// ring store
	bdq_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (agu_slot),
		.wdata (val_q),
		.raddr (agu_slot),
		.rdata (ram_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign cnt_zero = (count_q == '0);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, ring address selection and result capture
	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		count_d  = count_q;
		idx_d    = idx_q;
		rd_d     = rd_q;
		fpos_d   = fpos_q;
		status_d = status_q;
		agu_off  = '0;
		ram_we   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				rd_d     = '0;
				fpos_d   = '0;
				status_d = ST_OK;
				idx_d    = '0;
				state_d  = S_DONE;
				case (req_q)
					REQ_PUSH_TAIL: begin
						agu_off = PTR_W'(count_q);
						if (is_full) begin
							status_d = ST_FULL;
						end else begin
							ram_we  = 1'b1;
							count_d = count_q + CNT_W'(1);
						end
					end
					REQ_PUSH_HEAD: begin
						// one step back around the ring
						agu_off = PTR_W'(DEPTH - 1);
						if (is_full) begin
							status_d = ST_FULL;
						end else begin
							ram_we  = 1'b1;
							head_d  = agu_slot;
							count_d = count_q + CNT_W'(1);
						end
					end
					REQ_POP_TAIL: begin
						if (cnt_zero) begin
							status_d = ST_EMPTY;
						end else begin
							count_d = count_q - CNT_W'(1);
						end
					end
					REQ_POP_HEAD: begin
						agu_off = PTR_W'(1);
						if (cnt_zero) begin
							status_d = ST_EMPTY;
						end else begin
							head_d  = agu_slot;
							count_d = count_q - CNT_W'(1);
						end
					end
					REQ_READ: begin
						agu_off = PTR_W'(pos_q);
						if (CMP_W'(pos_q) >= CMP_W'(count_q)) begin
							status_d = ST_RANGE;
						end else begin
							state_d = S_RDWAIT;
						end
					end
					REQ_FIND: begin
						agu_off = '0;
						if (cnt_zero) begin
							status_d = ST_EMPTY;
						end else begin
							state_d = S_SCAN;
						end
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
			end
			S_RDWAIT: begin
				rd_d    = to_output(ram_rdata);
				state_d = S_DONE;
			end
			S_SCAN: begin
				// read data belongs to entry idx_q; next read is already issued
				agu_off = idx_q + PTR_W'(1);
				if (agu_hit) begin
					fpos_d  = idx_q;
					state_d = S_DONE;
				end else if ((CNT_W'(idx_q) + CNT_W'(1)) >= count_q) begin
					status_d = ST_NOTFOUND;
					state_d  = S_DONE;
				end else begin
					idx_d = idx_q + PTR_W'(1);
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// deque pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// request capture and work registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= req_t'(s_tuser);
			val_q <= from_input(s_tdata[ITEM_W-1:0]);
			pos_q <= s_tdata[ITEM_W +: POS_W];
		end
		idx_q    <= idx_d;
		rd_q     <= rd_d;
		fpos_q   <= fpos_d;
		status_q <= status_d;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.read_value     <= rd_q;
			out_q.found_position <= FPOS_W'(fpos_q);
			out_q.status         <= status_q;
			out_q.entry_count    <= COUNT_OUT_W'(count_q);
			out_q.empty_flag     <= cnt_zero;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'(out_q);

endmodule

[dv/tb_top.sv]
// tb_top: stand-alone testbench for bounded_deque_with_search_unit
// drives s_* requests; checks each m_* result against a plan row or deque predictor
// depends on rtl/bdq_pkg.sv and rtl/bounded_deque_with_search_unit.sv
module tb_top;
	import bdq_pkg::*;

	// unused request codes, accepted by the block and ignored
	localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 1720;
	localparam int CALM_ITEMS   = 150;
	localparam int DRAIN_EVERY  = 400;
	// cycles with no transfer on either side before the run is abandoned;
	// the slowest correct gap is a full find plus a stall on each side
	localparam int STALL_LIMIT  = 4000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;  // item_value, position
	logic [REQ_W-1:0]      s_tuser;  // req_type
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;  // read_value, found_position, status,
	                                 // entry_count, empty_flag

	// predictor state: ring store, head slot and entry count
	logic [VALUE_BITS-1:0] dq_store [DEPTH];
	logic [PTR_W-1:0]      dq_head;
	int                    dq_count;

	result_t pending_results [$];
	int      fail_count;
	int      stall_cycles;
	bit      calm;

	// request currently offered on s_*, with its typed expectation if it has one
	bit      cur_known;
	result_t cur_typed;

	typedef struct {
		logic [REQ_W-1:0]       req;
		logic [ITEM_W-1:0]      val;
		logic [POS_W-1:0]       pos;
		int                     reps;
		bit                     known;
		logic [ITEM_W-1:0]      rd;
		logic [FPOS_W-1:0]      fpos;
		status_t                st;
		logic [COUNT_OUT_W-1:0] cnt;
	} plan_row_t;

	// directed opening; rows with known cleared are checked by the predictor only
	plan_row_t dir_plan [21] = '{
		'{REQ_POP_TAIL,  32'h0,        8'h00, 1,  1'b1, 32'h0,        4'd0, ST_EMPTY,    5'd0},
		'{REQ_POP_HEAD,  32'h0,        8'h00, 1,  1'b1, 32'h0,        4'd0, ST_EMPTY,    5'd0},
		'{REQ_READ,      32'h0,        8'h00, 1,  1'b1, 32'h0,        4'd0, ST_RANGE,    5'd0},
		'{REQ_FIND,      32'h0,        8'h00, 1,  1'b1, 32'h0,        4'd0, ST_EMPTY,    5'd0},
		'{REQ_SPARE_6,   32'hFFFFFFFF, 8'hFF, 1,  1'b1, 32'h0,        4'd0, ST_OK,       5'd0},
		'{REQ_PUSH_TAIL, 32'h7FFFFFFF, 8'h00, 1,  1'b1, 32'h0,        4'd0, ST_OK,       5'd1},
		'{REQ_PUSH_HEAD, 32'h80000000, 8'h00, 1,  1'b1, 32'h0,        4'd0, ST_OK,       5'd2},
		'{REQ_READ,      32'h0,        8'h00, 1,  1'b1, 32'h80000000, 4'd0, ST_OK,       5'd2},
		'{REQ_READ,      32'h0,        8'h01, 1,  1'b1, 32'h7FFFFFFF, 4'd0, ST_OK,       5'd2},
		'{REQ_READ,      32'h0,        8'hFF, 1,  1'b1, 32'h0,        4'd0, ST_RANGE,    5'd2},
		'{REQ_FIND,      32'h7FFFFFFF, 8'h00, 1,  1'b1, 32'h0,        4'd1, ST_OK,       5'd2},
		'{REQ_FIND,      32'h0,        8'h00, 1,  1'b1, 32'h0,        4'd0, ST_NOTFOUND, 5'd2},
		// duplicate at the front: find must report the first match
		'{REQ_PUSH_HEAD, 32'h7FFFFFFF, 8'h00, 1,  1'b0, 32'h0,        4'd0, ST_OK,       5'd0},
		'{REQ_FIND,      32'h7FFFFFFF, 8'h00, 1,  1'b1, 32'h0,        4'd0, ST_OK,       5'd3},
		// fill to capacity, then push into a full store from both ends
		'{REQ_PUSH_TAIL, 32'hA5A5A5A5, 8'h00, 13, 1'b0, 32'h0,        4'd0, ST_OK,       5'd0},
		'{REQ_PUSH_TAIL, 32'h1,        8'h00, 1,  1'b1, 32'h0,        4'd0, ST_FULL,     5'd16},
		'{REQ_PUSH_HEAD, 32'h2,        8'h00, 1,  1'b1, 32'h0,        4'd0, ST_FULL,     5'd16},
		'{REQ_READ,      32'h0,        8'h10, 1,  1'b1, 32'h0,        4'd0, ST_RANGE,    5'd16},
		// match in the last position
		'{REQ_FIND,      32'hA5A5A5B1, 8'h00, 1,  1'b0, 32'h0,        4'd0, ST_OK,       5'd0},
		'{REQ_POP_HEAD,  32'h0,        8'h00, 1,  1'b0, 32'h0,        4'd0, ST_OK,       5'd0},
		'{REQ_SPARE_7,   32'h0,        8'h00, 1,  1'b0, 32'h0,        4'd0, ST_OK,       5'd0}
	};

	bounded_deque_with_search_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ring position of the entry at a given offset from the front
	function automatic logic [PTR_W-1:0] ring_slot(input int offset);
		return PTR_W'((int'(dq_head) + offset) % DEPTH);
	endfunction

	// apply one request to the predictor state and return its result
	function automatic result_t apply_request(input logic [REQ_W-1:0] req,
			input logic [ITEM_W-1:0] val, input logic [POS_W-1:0] pos);
		result_t               r;
		logic [VALUE_BITS-1:0] key;
		logic signed [63:0]    wide;
		bit                    hit;
		r = '0;
		r.status = ST_OK;
		wide = 64'(signed'(val));
		key = wide[VALUE_BITS-1:0];
		case (req)
			REQ_PUSH_TAIL: begin
				if (dq_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					dq_store[ring_slot(dq_count)] = key;
					dq_count++;
				end
			end
			REQ_PUSH_HEAD: begin
				if (dq_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					dq_head = (dq_head == 0) ? PTR_W'(DEPTH - 1) : dq_head - 1'b1;
					dq_store[dq_head] = key;
					dq_count++;
				end
			end
			REQ_POP_TAIL: begin
				if (dq_count == 0) r.status = ST_EMPTY;
				else dq_count--;
			end
			REQ_POP_HEAD: begin
				if (dq_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					dq_head = ring_slot(1);
					dq_count--;
				end
			end
			REQ_READ: begin
				if (int'(pos) >= dq_count) begin
					r.status = ST_RANGE;
				end else begin
					wide = 64'(signed'(dq_store[ring_slot(int'(pos))]));
					r.read_value = wide[ITEM_W-1:0];
				end
			end
			REQ_FIND: begin
				if (dq_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					hit = 1'b0;
					for (int i = 0; i < dq_count; i++) begin
						if (!hit && dq_store[ring_slot(i)] == key) begin
							hit = 1'b1;
							r.found_position = FPOS_W'(i);
						end
					end
					if (!hit) r.status = ST_NOTFOUND;
				end
			end
			default: ;
		endcase
		r.entry_count = COUNT_OUT_W'(dq_count);
		r.empty_flag = (dq_count == 0);
		return r;
	endfunction

	// compare one result with the oldest expectation
	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result with nothing pending: %h", got);
			return;
		end
		want = pending_results[0];
		pending_results.delete(0);
		if (got.read_value !== want.read_value ||
				got.found_position !== want.found_position ||
				got.status !== want.status || got.entry_count !== want.entry_count ||
				got.empty_flag !== want.empty_flag) begin
			fail_count++;
			if (fail_count <= 10)
				$display({"mismatch at %0t: expected rd=%h fpos=%0d st=%0d cnt=%0d empty=%b,",
					" got rd=%h fpos=%0d st=%0d cnt=%0d empty=%b"},
					$realtime, want.read_value, want.found_position, want.status,
					want.entry_count, want.empty_flag, got.read_value, got.found_position,
					got.status, got.entry_count, got.empty_flag);
		end
	endtask

	// offer one request at a falling edge and hold it until the transfer
	task automatic drive_request(input logic [REQ_W-1:0] req, input logic [ITEM_W-1:0] val,
			input logic [POS_W-1:0] pos, input bit known, input result_t typed);
		cur_known = known;
		cur_typed = typed;
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= IN_DATA_W'({pos, val});
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// monitor: check results, predict accepted requests, watch for a hang
	always @(posedge clk) begin : monitor
		result_t predicted;
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result(result_t'(m_tdata[RES_W-1:0]));
			if (s_tvalid && s_tready) begin
				predicted = apply_request(s_tuser, s_tdata[ITEM_W-1:0],
					s_tdata[ITEM_W +: POS_W]);
				pending_results.insert(pending_results.size(),
					cur_known ? cur_typed : predicted);
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	// result side: random stall bursts, none in the closing stretch
	initial begin : result_sink
		bit rx_bursty;
		rx_bursty = 1'b1;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) == 0) rx_bursty = !rx_bursty;
			if (!calm && rx_bursty && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// request side: reset, directed plan, random traffic, drain and verdict
	initial begin : request_source
		logic [REQ_W-1:0]  req;
		logic [ITEM_W-1:0] val;
		logic [POS_W-1:0]  pos;
		result_t           typed;
		int                pick;
		bit                filling;
		bit                tx_bursty;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cur_known = 1'b0;
		cur_typed = '0;
		fail_count = 0;
		stall_cycles = 0;
		calm = 1'b0;
		dq_head = '0;
		dq_count = 0;
		filling = 1'b1;
		tx_bursty = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed plan
		foreach (dir_plan[i]) begin
			for (int k = 0; k < dir_plan[i].reps; k++) begin
				typed = '0;
				typed.read_value = dir_plan[i].rd;
				typed.found_position = dir_plan[i].fpos;
				typed.status = dir_plan[i].st;
				typed.entry_count = dir_plan[i].cnt;
				typed.empty_flag = (dir_plan[i].cnt == 0);
				drive_request(dir_plan[i].req, dir_plan[i].val + ITEM_W'(k), dir_plan[i].pos,
					dir_plan[i].known, typed);
			end
		end

		// random traffic, swinging between filling and draining the store
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			if (!calm && n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
				s_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
				@(negedge clk);
			end
			if (n % 64 == 0) tx_bursty = ($urandom_range(0, 1) == 1);
			if (!calm && tx_bursty && $urandom_range(0, 3) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end

			if (dq_count == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
			else if (dq_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
			else if ($urandom_range(0, 39) == 0) filling = !filling;

			// value: extremes, a small set that repeats, or anything
			case ($urandom_range(0, 9))
				0: val = 32'h7FFFFFFF;
				1: val = 32'h80000000;
				2: val = 32'h0;
				3: val = 32'hFFFFFFFF;
				4, 5: val = ITEM_W'($urandom_range(0, 7));
				default: val = $urandom();
			endcase
			pos = POS_W'($urandom_range(0, 255));

			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				req = (pick == 0) ? REQ_SPARE_6 : REQ_SPARE_7;
			end else if (pick < 56) begin
				if ((pick < 44) == filling)
					req = $urandom_range(0, 1) ? REQ_PUSH_HEAD : REQ_PUSH_TAIL;
				else
					req = $urandom_range(0, 1) ? REQ_POP_HEAD : REQ_POP_TAIL;
			end else if (pick < 78) begin
				req = REQ_READ;
				if (dq_count > 0 && $urandom_range(0, 3) != 0)
					pos = POS_W'($urandom_range(0, dq_count - 1));
				else if ($urandom_range(0, 1) == 0)
					pos = POS_W'(dq_count);
			end else begin
				req = REQ_FIND;
				if (dq_count > 0 && $urandom_range(0, 9) < 6)
					val = ITEM_W'(signed'(dq_store[ring_slot($urandom_range(0, dq_count - 1))]));
			end
			drive_request(req, val, pos, 1'b0, '0);
		end

		// let the last results come back, then a short quiet tail
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_agu.sv
rtl/bounded_deque_with_search_unit.sv
dv/tb_top.sv
